[hdl/modular_arithmetic_unit_top_defines.svh]
// assertion macros shared by the checker; clock and reset come from the using scope
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define MAU_ASSERT_IMP(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) else $error("lbl");
`define MAU_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) else $error("lbl");
`endif

[hdl/mau_pkg.sv]
`default_nettype none
package mau_pkg;
   localparam int WORD_WIDTH_DEF = 32;
   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2,
      CMD_DIV = 3'd3, CMD_INV = 3'd4, CMD_POW = 3'd5,
      CMD_RSV6 = 3'd6, CMD_RSV7 = 3'd7
   } cmd_type;
   typedef enum logic [1:0] {
      DIV_IDLE, DIV_RUN, DIV_DONE
   } div_state_type;
   typedef enum logic [4:0] {
      ST_IDLE, ST_RED_A, ST_RED_A_W, ST_RED_B, ST_RED_B_W, ST_DISPATCH,
      ST_MM_MUL, ST_MM_MUL_W, ST_MM_RED, ST_MM_RED_W, ST_RES_PROD,
      ST_EUC_CHK, ST_EUC_DIV, ST_EUC_DIV_W, ST_EUC_T, ST_EUC_END,
      ST_POW_SQ, ST_POW_MB, ST_POW_ACC, ST_POW_NEXT, ST_OUT
   } state_type;
endpackage
`default_nettype wire

[hdl/mau_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle; divides a 2W-bit value by W-bit.
// Only the low W quotient bits leave the block.
module mau_divider #(
   parameter int W = mau_pkg::WORD_WIDTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [2*W-1:0] dividend,
   input  wire logic [W-1:0]   divisor,
   output logic                done,
   output logic [W-1:0]        quotient,
   output logic [W-1:0]        remainder
);
   import mau_pkg::*;
   localparam int CW = $clog2(2 * W + 1);
   div_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W:0] rem_ff, rem_in;
   logic [2*W-1:0] quo_ff, quo_in;
   logic [W-1:0] dsr_ff, dsr_in;
   logic [W:0] trial;
   logic [W+1:0] diff;

   always_comb begin
      trial = {rem_ff[W-1:0], quo_ff[2*W-1]};
      diff = {1'b0, trial} - {2'b00, dsr_ff};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN: if (count_ff == CW'(2 * W - 1)) state_in = DIV_DONE;
         DIV_DONE: state_in = DIV_IDLE;
         default: state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      case (state_ff)
         DIV_IDLE: if (start) begin
            count_in = '0;
            rem_in = '0;
            quo_in = dividend;
            dsr_in = divisor;
         end
         DIV_RUN: begin
            count_in = count_ff + 1'b1;
            if (!diff[W+1]) begin
               rem_in = diff[W:0];
               quo_in = {quo_ff[2*W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[2*W-2:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done = (state_ff == DIV_DONE);
   assign quotient = quo_ff[W-1:0];
   assign remainder = rem_ff[W-1:0];
endmodule
`default_nettype wire

[hdl/mau_multiplier.sv]
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle, W x W -> 2W.
module mau_multiplier #(
   parameter int W = mau_pkg::WORD_WIDTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [W-1:0]   mcand,
   input  wire logic [W-1:0]   mplier,
   output logic                done,
   output logic [2*W-1:0]      product
);
   import mau_pkg::*;
   localparam int CW = $clog2(W + 1);
   div_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2*W-1:0] acc_ff, acc_in;
   logic [W-1:0] mc_ff, mc_in;
   logic [W-1:0] mp_ff, mp_in;
   logic [W:0] upper;

   always_comb begin
      upper = {1'b0, acc_ff[2*W-1:W]} + (mp_ff[0] ? {1'b0, mc_ff} : '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN: if (count_ff == CW'(W - 1)) state_in = DIV_DONE;
         DIV_DONE: state_in = DIV_IDLE;
         default: state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      acc_in = acc_ff;
      mc_in = mc_ff;
      mp_in = mp_ff;
      case (state_ff)
         DIV_IDLE: if (start) begin
            count_in = '0;
            acc_in = '0;
            mc_in = mcand;
            mp_in = mplier;
         end
         DIV_RUN: begin
            count_in = count_ff + 1'b1;
            acc_in = {upper, acc_ff[W-1:1]};
            mp_in = {1'b0, mp_ff[W-1:1]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
   end

   assign done = (state_ff == DIV_DONE);
   assign product = acc_ff;
endmodule
`default_nettype wire

[hdl/modular_arithmetic_unit_top.sv]
// Every command first reduces both operands modulo m; multiply then runs a multiply and
// a reduction; divide/inverse run extended Euclid steps, divide adding a final multiply;
// power squares once per exponent bit and multiplies once more per set bit.
// One item at a time: a new request is taken only back in idle after the result beat,
// so the block takes no new item before it is through with the last one.
// Reset is synchronous: controller idle, modulus back to 2.
`default_nettype none
module modular_arithmetic_unit_top #(
   parameter int WORD_WIDTH = mau_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [WORD_WIDTH-1:0] csr_modulus,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_command,
   input  wire logic [WORD_WIDTH-1:0] req_operand_a,
   input  wire logic [WORD_WIDTH-1:0] req_operand_b,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [WORD_WIDTH-1:0]      rsp_result,
   output logic                       rsp_status
);
   import mau_pkg::*;
   localparam int W = WORD_WIDTH;
   localparam int BW = $clog2(W);

   state_type state_ff, state_in, ret_ff;
   logic [W-1:0] mod_ff;
   cmd_type cmd_ff;
   logic [W-1:0] a_ff, b_ff, e_ff, acc_ff;
   logic [BW-1:0] bit_ff;
   // Euclid registers; t kept modulo m, so no sign is needed
   logic [W-1:0] r0_ff, r1_ff, t0_ff, t1_ff;
   // operands and result of the shared multiply-then-reduce sequence
   logic [W-1:0] mx_ff, my_ff, prod_ff;
   logic [W-1:0] res_ff;
   logic st_ff;

   logic dv_start, mu_start, dv_done, mu_done;
   logic [2*W-1:0] dv_dividend, mu_prod;
   logic [W-1:0] dv_divisor, dv_quo, dv_rem;
   logic [W:0] sum, sum_wrap;

   mau_divider #(.W(W)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .dividend(dv_dividend),
      .divisor(dv_divisor), .done(dv_done), .quotient(dv_quo), .remainder(dv_rem)
   );
   mau_multiplier #(.W(W)) u_mul (
      .clock(clock), .reset(reset), .start(mu_start), .mcand(mx_ff), .mplier(my_ff),
      .done(mu_done), .product(mu_prod)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_RED_A;
         ST_RED_A: state_in = ST_RED_A_W;
         ST_RED_A_W: if (dv_done) state_in = ST_RED_B;
         ST_RED_B: state_in = ST_RED_B_W;
         ST_RED_B_W: if (dv_done) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (mod_ff == '0) state_in = ST_OUT;
            else case (cmd_ff)
               CMD_MUL: state_in = ST_MM_MUL;
               CMD_DIV, CMD_INV: state_in = ST_EUC_CHK;
               CMD_POW: state_in = ST_POW_SQ;
               default: state_in = ST_OUT;
            endcase
         end
         ST_MM_MUL: state_in = ST_MM_MUL_W;
         ST_MM_MUL_W: if (mu_done) state_in = ST_MM_RED;
         ST_MM_RED: state_in = ST_MM_RED_W;
         ST_MM_RED_W: if (dv_done) state_in = ret_ff;
         ST_RES_PROD: state_in = ST_OUT;
         ST_EUC_CHK: state_in = (r1_ff == '0) ? ST_EUC_END : ST_EUC_DIV;
         ST_EUC_DIV: state_in = ST_EUC_DIV_W;
         ST_EUC_DIV_W: if (dv_done) state_in = ST_MM_MUL;
         ST_EUC_T: state_in = ST_EUC_CHK;
         ST_EUC_END: begin
            if (r0_ff == W'(1) && cmd_ff == CMD_DIV) state_in = ST_MM_MUL;
            else state_in = ST_OUT;
         end
         ST_POW_SQ: state_in = ST_MM_MUL;
         ST_POW_MB: state_in = e_ff[W-1] ? ST_MM_MUL : ST_POW_NEXT;
         ST_POW_ACC: state_in = ST_POW_NEXT;
         ST_POW_NEXT: state_in = (bit_ff == '0) ? ST_OUT : ST_POW_SQ;
         ST_OUT: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dv_start = 1'b0;
      mu_start = 1'b0;
      dv_dividend = '0;
      dv_divisor = mod_ff;
      case (state_ff)
         ST_RED_A: begin
            dv_start = 1'b1;
            dv_dividend = {{W{1'b0}}, a_ff};
         end
         ST_RED_B: begin
            dv_start = 1'b1;
            dv_dividend = {{W{1'b0}}, b_ff};
         end
         ST_MM_MUL: mu_start = 1'b1;
         ST_MM_RED: begin
            dv_start = 1'b1;
            dv_dividend = mu_prod;
         end
         ST_EUC_DIV: begin
            dv_start = 1'b1;
            dv_dividend = {{W{1'b0}}, r0_ff};
            dv_divisor = r1_ff;
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_result = res_ff;
   assign rsp_status = st_ff;

   assign sum = {1'b0, a_ff} + {1'b0, b_ff};
   assign sum_wrap = sum - {1'b0, mod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff <= W'(2);
      end else begin
         state_ff <= state_in;
         if (csr_write) mod_ff <= csr_modulus;
      end
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd_ff <= cmd_type'(req_command);
            a_ff <= req_operand_a;
            b_ff <= req_operand_b;
            e_ff <= req_operand_b;
         end
         ST_RED_A_W: if (dv_done) a_ff <= dv_rem;
         ST_RED_B_W: if (dv_done) b_ff <= dv_rem;
         ST_DISPATCH: begin
            res_ff <= '0;
            st_ff <= 1'b0;
            mx_ff <= a_ff;
            my_ff <= b_ff;
            ret_ff <= ST_RES_PROD;
            r0_ff <= mod_ff;
            r1_ff <= (cmd_ff == CMD_INV) ? a_ff : b_ff;
            t0_ff <= '0;
            t1_ff <= W'(1);
            acc_ff <= (mod_ff == W'(1)) ? '0 : W'(1);
            bit_ff <= BW'(W - 1);
            if (mod_ff != '0) begin
               case (cmd_ff)
                  CMD_ADD: res_ff <= (sum >= {1'b0, mod_ff}) ? sum_wrap[W-1:0] : sum[W-1:0];
                  CMD_SUB: res_ff <= (a_ff >= b_ff) ? a_ff - b_ff : a_ff + mod_ff - b_ff;
                  default: ;
               endcase
            end
         end
         ST_MM_RED_W: if (dv_done) prod_ff <= dv_rem;
         ST_RES_PROD: res_ff <= prod_ff;
         ST_EUC_DIV_W: if (dv_done) begin
            r0_ff <= r1_ff;
            r1_ff <= dv_rem;
            mx_ff <= dv_quo;
            my_ff <= t1_ff;
            ret_ff <= ST_EUC_T;
         end
         ST_EUC_T: begin
            t0_ff <= t1_ff;
            t1_ff <= (t0_ff >= prod_ff) ? t0_ff - prod_ff : t0_ff + mod_ff - prod_ff;
         end
         ST_EUC_END: begin
            // gcd other than 1: no inverse, result stays 0
            if (r0_ff != W'(1)) st_ff <= 1'b1;
            else if (cmd_ff == CMD_INV) res_ff <= t0_ff;
            mx_ff <= a_ff;
            my_ff <= t0_ff;
            ret_ff <= ST_RES_PROD;
         end
         ST_POW_SQ: begin
            mx_ff <= acc_ff;
            my_ff <= acc_ff;
            ret_ff <= ST_POW_MB;
         end
         ST_POW_MB: begin
            acc_ff <= prod_ff;
            mx_ff <= prod_ff;
            my_ff <= a_ff;
            ret_ff <= ST_POW_ACC;
         end
         ST_POW_ACC: acc_ff <= prod_ff;
         ST_POW_NEXT: begin
            e_ff <= {e_ff[W-2:0], 1'b0};
            bit_ff <= bit_ff - 1'b1;
            res_ff <= acc_ff;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

[hdl/mau_checker.sv]
`default_nettype none
`include "modular_arithmetic_unit_top_defines.svh"
module mau_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_status,
   input wire logic [31:0] rsp_result
);
   `MAU_ASSERT_IMP(busy_while_out, rsp_valid, req_stall)
   `MAU_ASSERT_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_status, rsp_result}))
   `MAU_ASSERT_IMP(fail_zero, rsp_valid && rsp_status, rsp_result == 32'd0)
   `MAU_ASSERT_NEXT(busy_after_take, req_valid && !req_stall, req_stall)
endmodule
bind modular_arithmetic_unit_top mau_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_result(rsp_result)
);
`default_nettype wire
